// ===== hdl/fdem_pkg.sv =====
// ----------------------------------------------------------------------------
// fdem_pkg
// Shared types and constants of the fault debounce and event manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fdem_pkg;

	// Sizing of the stores.
	localparam int PORTS       = 2;
	localparam int NUM_CODES   = 64;
	localparam int SLOTS       = 32;
	localparam int QUEUE_DEPTH = 16;

	// Field widths.
	localparam int KIND_W  = 3;
	localparam int PORT_W  = 1;
	localparam int SLOT_W  = 5;
	localparam int CODE_W  = 6;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;
	localparam int LIMIT_W = 7;
	localparam int MINC_W  = 16;
	localparam int CFG_W   = 64;
	localparam int CFGI_W  = 2;

	// Derived sizes.
	localparam int FLAG_DEPTH  = PORTS * NUM_CODES;
	localparam int FLAG_AW     = PORT_W + CODE_W;
	localparam int STAMP_DEPTH = PORTS * SLOTS;
	localparam int STAMP_AW    = PORT_W + SLOT_W;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QMEM_DEPTH  = PORTS * QUEUE_DEPTH;
	localparam int QMEM_AW     = PORT_W + QIDX_W;
	localparam int REPORT_W    = CODE_W + 1;

	// Stream widths.
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 24;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_CHECK = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOP  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROP = 2'd2;

	// Configuration register indexes.
	localparam logic [CFGI_W-1:0] CFG_CODE_LIMIT = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_STOP_MASK  = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_MIN_CLEAR  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] CODE_LIMIT_RST = 7'd46;
	localparam logic [MINC_W-1:0]  MIN_CLEAR_RST  = 16'd200;

	// One entry of the debounce slot table.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] appear;
		logic [TIME_W-1:0] disappear;
	} slot_ent_t;

	// Requests from the sequencer to the report queue.
	typedef struct packed {
		logic              rd;
		logic              push;
		logic              pop;
		logic              push_set;
		logic [CODE_W-1:0] push_code;
	} qctl_t;

	// Queue status of the selected port.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

`default_nettype wire

// ===== hdl/fdem_report_queue.sv =====
// ----------------------------------------------------------------------------
// fdem_report_queue
// Per-port report FIFOs sharing one synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fdem_report_queue (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [fdem_pkg::PORT_W-1:0]       port,
	input  wire fdem_pkg::qctl_t                   ctl,
	output fdem_pkg::qstat_t                       stat,
	output logic [fdem_pkg::REPORT_W-1:0]          rd_data
);

	logic [fdem_pkg::REPORT_W-1:0] mem [fdem_pkg::QMEM_DEPTH];
	logic [fdem_pkg::QCNT_W-1:0]   count_q [fdem_pkg::PORTS];
	logic [fdem_pkg::QIDX_W-1:0]   head_q  [fdem_pkg::PORTS];
	logic [fdem_pkg::REPORT_W-1:0] rd_data_q;
	logic [fdem_pkg::QIDX_W-1:0]   tail;

	// The tail wraps naturally because the index is exactly log2 of the depth.
	assign tail = head_q[port] + count_q[port][fdem_pkg::QIDX_W-1:0];

	assign stat.empty = (count_q[port] == '0);
	assign stat.full  = (count_q[port] == fdem_pkg::QCNT_W'(fdem_pkg::QUEUE_DEPTH));
	assign rd_data    = rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem[{port, head_q[port]}];
		end
		if (ctl.push) begin
			mem[{port, tail}] <= {ctl.push_set, ctl.push_code};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fdem_pkg::PORTS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else begin
			if (ctl.push) begin
				count_q[port] <= count_q[port] + 1'b1;
			end else if (ctl.pop) begin
				count_q[port] <= count_q[port] - 1'b1;
				head_q[port]  <= head_q[port] + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fault_debounce_event_manager_top.sv =====
// ----------------------------------------------------------------------------
// fault_debounce_event_manager_top
// Per-port fault manager with debounce slots and report queues.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the kind (check, direct
// set, direct clear, pop, load slot) and s_tdata the remaining fields. Every
// request yields exactly one result on the m_ stream.
// A request goes through an accept, a lookup and an execute cycle: the accept
// cycle reads the slot table and the debounce stamp, the lookup cycle reads the
// fault flag (whose address may come from the slot table) and the report queue
// and compares the elapsed time, and the execute cycle writes back flag, stamp,
// slot table and queue and loads the result register. Because of the chained
// memory reads, a new request is accepted only once the previous one has left
// its execute cycle.
// The result register lets a new request be accepted while a finished result
// is still waiting. When the receiver stalls, the next request waits in its
// execute cycle until the result register frees up, so nothing is lost.
// Reset clears all fault flags, stamps, latched stop codes and queues at once
// through valid bits and counters; the slot table holds nothing until loaded.
// Configuration writes (cfg_we) are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fault_debounce_event_manager_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             cfg_we,
	input  wire logic [fdem_pkg::CFGI_W-1:0]      cfg_index,
	input  wire logic [fdem_pkg::CFG_W-1:0]       cfg_data,
	// Request stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata from bit 0: port[0], slot[5:1], code[11:6], raw_on[12],
	// now_ms[44:13], appear_ms[76:45], disappear_ms[108:77], zero fill above.
	input  wire logic [fdem_pkg::IN_DATA_W-1:0]   s_tdata,
	// s_tuser: kind[2:0].
	input  wire logic [fdem_pkg::KIND_W-1:0]      s_tuser,
	// Result stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata from bit 0: status[1:0], fault_present[2], changed[3],
	// first_stop_code[9:4], report_valid[10], report_code[16:11],
	// report_set[17], zero fill above.
	output logic [fdem_pkg::OUT_DATA_W-1:0]       m_tdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;

	// Configuration registers.
	logic [fdem_pkg::LIMIT_W-1:0] code_limit_q;
	logic [fdem_pkg::CFG_W-1:0]   stop_mask_q;
	logic [fdem_pkg::MINC_W-1:0]  min_clear_q;

	// Unpacked request fields.
	logic [fdem_pkg::PORT_W-1:0] in_port;
	logic [fdem_pkg::SLOT_W-1:0] in_slot;
	logic [fdem_pkg::CODE_W-1:0] in_code;
	logic                        in_raw;
	logic [fdem_pkg::TIME_W-1:0] in_now;
	logic [fdem_pkg::TIME_W-1:0] in_appear;
	logic [fdem_pkg::TIME_W-1:0] in_disappear;

	// Request held through the lookup and execute cycles.
	logic [fdem_pkg::KIND_W-1:0] kind_s1;
	logic [fdem_pkg::PORT_W-1:0] port_s1;
	logic [fdem_pkg::SLOT_W-1:0] slot_s1;
	logic [fdem_pkg::CODE_W-1:0] code_s1;
	logic                        raw_s1;
	logic [fdem_pkg::TIME_W-1:0] now_s1;
	logic [fdem_pkg::TIME_W-1:0] appear_s1;
	logic [fdem_pkg::TIME_W-1:0] disappear_s1;

	// Values resolved in the lookup cycle.
	logic [fdem_pkg::CODE_W-1:0] code_s2;
	logic                        set_pass_s2;
	logic                        clr_pass_s2;

	// Slot table: undefined until loaded.
	fdem_pkg::slot_ent_t slot_mem [fdem_pkg::SLOTS];
	fdem_pkg::slot_ent_t slot_rd_q;

	// Debounce stamps: an entry that was never written reads as zero.
	logic [fdem_pkg::TIME_W-1:0]      stamp_mem [fdem_pkg::STAMP_DEPTH];
	logic [fdem_pkg::STAMP_DEPTH-1:0] stamp_vld_q;
	logic [fdem_pkg::TIME_W-1:0]      stamp_rd_q;
	logic                             stamp_vld_rd_q;

	// Fault flags: an entry that was never written reads as cleared.
	logic                            flag_mem [fdem_pkg::FLAG_DEPTH];
	logic [fdem_pkg::FLAG_DEPTH-1:0] flag_vld_q;
	logic                            flag_rd_q;
	logic                            flag_vld_rd_q;

	// Latched first stop-class code per port.
	logic [fdem_pkg::CODE_W-1:0] first_stop_q [fdem_pkg::PORTS];

	// Result register.
	logic                            m_tvalid_q;
	logic [fdem_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// Queue interface.
	fdem_pkg::qctl_t                q_ctl;
	fdem_pkg::qstat_t               q_stat;
	logic [fdem_pkg::REPORT_W-1:0] q_rd_data;

	// Lookup cycle logic.
	logic [fdem_pkg::CODE_W-1:0] code_eff;
	logic [fdem_pkg::TIME_W-1:0] stamp_cur;
	logic [fdem_pkg::TIME_W-1:0] elapsed;
	logic [fdem_pkg::TIME_W-1:0] clr_delay;
	logic [fdem_pkg::FLAG_AW-1:0] flag_rd_addr;

	// Execute cycle logic.
	logic                        accept;
	logic                        exec_go;
	logic                        flag_cur;
	logic                        code_ok;
	logic                        op_set;
	logic                        op_clr;
	logic                        set_ok;
	logic                        clr_ok;
	logic                        chg;
	logic                        flag_new;
	logic                        stamp_we;
	logic                        slot_we;
	logic                        pop_ok;
	logic [fdem_pkg::STAT_W-1:0] status;
	logic [fdem_pkg::CODE_W-1:0] fs_cur;
	logic [fdem_pkg::CODE_W-1:0] fs_new;
	logic [fdem_pkg::FLAG_AW-1:0]  flag_wr_addr;
	logic [fdem_pkg::STAMP_AW-1:0] stamp_wr_addr;
	logic [fdem_pkg::STAMP_AW-1:0] stamp_rd_addr;

	assign in_port      = s_tdata[0];
	assign in_slot      = s_tdata[5:1];
	assign in_code      = s_tdata[11:6];
	assign in_raw       = s_tdata[12];
	assign in_now       = s_tdata[44:13];
	assign in_appear    = s_tdata[76:45];
	assign in_disappear = s_tdata[108:77];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign exec_go  = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q <= fdem_pkg::CODE_LIMIT_RST;
			stop_mask_q  <= '0;
			min_clear_q  <= fdem_pkg::MIN_CLEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fdem_pkg::CFG_CODE_LIMIT: code_limit_q <= cfg_data[fdem_pkg::LIMIT_W-1:0];
				fdem_pkg::CFG_STOP_MASK:  stop_mask_q  <= cfg_data;
				fdem_pkg::CFG_MIN_CLEAR:  min_clear_q  <= cfg_data[fdem_pkg::MINC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the request.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1      <= s_tuser;
			port_s1      <= in_port;
			slot_s1      <= in_slot;
			code_s1      <= in_code;
			raw_s1       <= in_raw;
			now_s1       <= in_now;
			appear_s1    <= in_appear;
			disappear_s1 <= in_disappear;
		end
	end

	// ------------------------------------------------------------------
	// Accept cycle: slot table and stamp reads.
	// ------------------------------------------------------------------
	assign stamp_rd_addr = {in_port, in_slot};

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_rd_q  <= slot_mem[in_slot];
			stamp_rd_q <= stamp_mem[stamp_rd_addr];
		end
		if (slot_we) begin
			slot_mem[slot_s1] <= '{code: code_s1, appear: appear_s1, disappear: disappear_s1};
		end
		if (stamp_we) begin
			stamp_mem[stamp_wr_addr] <= now_s1;
		end
	end

	// ------------------------------------------------------------------
	// Lookup cycle: a check takes its code from the slot; both debounce
	// comparisons are prepared, the execute cycle picks one by the flag.
	// ------------------------------------------------------------------
	assign code_eff     = (kind_s1 == fdem_pkg::KIND_CHECK) ? slot_rd_q.code : code_s1;
	assign stamp_cur    = stamp_vld_rd_q ? stamp_rd_q : '0;
	assign elapsed      = now_s1 - stamp_cur;
	assign clr_delay    = (slot_rd_q.disappear < {16'd0, min_clear_q})
	                      ? {16'd0, min_clear_q} : slot_rd_q.disappear;
	assign flag_rd_addr = {port_s1, code_eff};

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			code_s2     <= code_eff;
			set_pass_s2 <= (elapsed >= slot_rd_q.appear);
			clr_pass_s2 <= (elapsed >= clr_delay);
			flag_rd_q   <= flag_mem[flag_rd_addr];
		end
		if (exec_go && chg) begin
			flag_mem[flag_wr_addr] <= flag_new;
		end
	end

	// Valid bits of flag and stamp stores, and their registered lookups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_vld_q     <= '0;
			stamp_vld_q    <= '0;
			flag_vld_rd_q  <= 1'b0;
			stamp_vld_rd_q <= 1'b0;
		end else begin
			if (accept) stamp_vld_rd_q <= stamp_vld_q[stamp_rd_addr];
			if (state_q == ST_LOOK) flag_vld_rd_q <= flag_vld_q[flag_rd_addr];
			if (exec_go && chg) flag_vld_q[flag_wr_addr] <= 1'b1;
			if (stamp_we) stamp_vld_q[stamp_wr_addr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Execute cycle.
	// ------------------------------------------------------------------
	assign flag_cur      = flag_vld_rd_q & flag_rd_q;
	assign code_ok       = (code_s2 != '0) && ({1'b0, code_s2} < code_limit_q);
	assign flag_wr_addr  = {port_s1, code_s2};
	assign stamp_wr_addr = {port_s1, slot_s1};
	assign fs_cur        = first_stop_q[port_s1];

	always_comb begin
		op_set   = 1'b0;
		op_clr   = 1'b0;
		stamp_we = 1'b0;
		slot_we  = 1'b0;
		pop_ok   = 1'b0;
		unique case (kind_s1)
			fdem_pkg::KIND_CHECK: begin
				// The stamp follows time while the raw condition agrees with
				// the flag, and restarts once the delay has run out.
				if (raw_s1 == flag_cur) begin
					stamp_we = exec_go;
				end else if (flag_cur ? clr_pass_s2 : set_pass_s2) begin
					stamp_we = exec_go;
					op_set   = !flag_cur;
					op_clr   = flag_cur;
				end
			end
			fdem_pkg::KIND_SET:   op_set  = 1'b1;
			fdem_pkg::KIND_CLEAR: op_clr  = 1'b1;
			fdem_pkg::KIND_POP:   pop_ok  = !q_stat.empty;
			fdem_pkg::KIND_LOAD:  slot_we = exec_go;
			default: begin
			end
		endcase

		set_ok   = op_set && code_ok && !flag_cur;
		clr_ok   = op_clr && code_ok && flag_cur;
		chg      = set_ok || clr_ok;
		flag_new = chg ? set_ok : flag_cur;

		if (chg) begin
			status = q_stat.full ? fdem_pkg::STAT_DROP : fdem_pkg::STAT_DONE;
		end else if (pop_ok || (kind_s1 == fdem_pkg::KIND_LOAD)) begin
			status = fdem_pkg::STAT_DONE;
		end else begin
			status = fdem_pkg::STAT_NOP;
		end

		// The first stop-class fault stays latched until that same fault clears.
		fs_new = fs_cur;
		if (set_ok && stop_mask_q[code_s2] && (fs_cur == '0)) begin
			fs_new = code_s2;
		end else if (clr_ok && (fs_cur == code_s2)) begin
			fs_new = '0;
		end

		q_ctl.rd        = (state_q == ST_LOOK);
		q_ctl.push      = exec_go && chg && !q_stat.full;
		q_ctl.pop       = exec_go && pop_ok;
		q_ctl.push_set  = set_ok;
		q_ctl.push_code = code_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fdem_pkg::PORTS; i++) begin
				first_stop_q[i] <= '0;
			end
		end else if (exec_go) begin
			first_stop_q[port_s1] <= fs_new;
		end
	end

	// Result register: cleared valid on reset, loaded when the item finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			m_tdata_q <= {6'd0,
			              pop_ok & q_rd_data[fdem_pkg::CODE_W],
			              pop_ok ? q_rd_data[fdem_pkg::CODE_W-1:0] : 6'd0,
			              pop_ok,
			              fs_new,
			              chg,
			              flag_new,
			              status};
		end
	end

	fdem_report_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.port    (port_s1),
		.ctl     (q_ctl),
		.stat    (q_stat),
		.rd_data (q_rd_data)
	);

endmodule

`default_nettype wire

// ===== tb/fault_debounce_event_manager_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fault_debounce_event_manager_top_test
// Self-checking bench for the per-port fault debounce and event manager.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and offered on the request
// stream by a clocked driver. Each accepted request runs through a cycle-free
// predictor of the fault flags, debounce stamps, stop latches and report
// queues, and its expected result is queued. A clocked monitor takes the
// results and compares them field by field. The run goes through several
// register settings and several idling patterns on both sides.
// ----------------------------------------------------------------------------

module fault_debounce_event_manager_top_test;
	import fdem_pkg::*;

	// One request, unpacked into its fields.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PORT_W-1:0] port;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] code;
		logic              raw_on;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] appear_ms;
		logic [TIME_W-1:0] disappear_ms;
	} fault_req_t;

	// One result, unpacked into its fields.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              present;
		logic              changed;
		logic [CODE_W-1:0] first_stop;
		logic              rep_valid;
		logic [CODE_W-1:0] rep_code;
		logic              rep_set;
	} fault_res_t;

	// Clock, reset and every input of the block start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// s_tdata from bit 0: port, slot, code, raw_on, now_ms, appear_ms,
	// disappear_ms, zero fill.
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// s_tuser: kind.
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// m_tdata from bit 0: status, fault_present, changed, first_stop_code,
	// report_valid, report_code, report_set, zero fill.
	logic [OUT_DATA_W-1:0] m_tdata;

	fault_debounce_event_manager_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Requests waiting to be offered, and results waiting to arrive.
	fault_req_t pending_reqs[$];
	fault_res_t expected_results[$];
	fault_req_t offered_req;

	// Mirror of the configuration registers.
	logic [LIMIT_W-1:0] limit_cfg;
	logic [CFG_W-1:0]   stop_mask_cfg;
	logic [MINC_W-1:0]  min_clear_cfg;

	// Mirror of the block's stores.
	logic                fault_on [PORTS][NUM_CODES];
	logic [CODE_W-1:0]   stop_latch [PORTS];
	logic [TIME_W-1:0]   debounce_ms [PORTS][SLOTS];
	logic [CODE_W-1:0]   slot_code_tab [SLOTS];
	logic [TIME_W-1:0]   slot_appear_tab [SLOTS];
	logic [TIME_W-1:0]   slot_clear_tab [SLOTS];
	logic [REPORT_W-1:0] report_mem [PORTS][QUEUE_DEPTH];
	int                  report_head [PORTS];
	int                  report_count [PORTS];

	// Stimulus state: which slots hold an entry, the raw condition that each
	// port and slot currently sees, and the running millisecond time.
	logic        slot_ready [SLOTS];
	logic        raw_wish [PORTS][SLOTS];
	logic [31:0] ms_cursor;

	// Idling pattern of the current phase, in percent.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int pop_pct = 20;

	// Long receiver hold-off, armed once by the stimulus process.
	logic hold_armed = 1'b0;
	logic hold_done;
	int   hold_left;

	int mismatch_count = 0;
	int result_count = 0;

	function automatic logic code_valid(input logic [CODE_W-1:0] c);
		return c != '0 && {1'b0, c} < limit_cfg;
	endfunction

	// Pushes a report into the port's queue; a full queue drops it.
	function automatic logic log_report(input int p, input logic [CODE_W-1:0] c,
			input logic set_flag);
		if (report_count[p] >= QUEUE_DEPTH)
			return 1'b0;
		report_mem[p][(report_head[p] + report_count[p]) % QUEUE_DEPTH] = {set_flag, c};
		report_count[p]++;
		return 1'b1;
	endfunction

	function automatic logic [STAT_W-1:0] raise_fault(input int p,
			input logic [CODE_W-1:0] c);
		if (!code_valid(c) || fault_on[p][c])
			return STAT_NOP;
		fault_on[p][c] = 1'b1;
		// Only the first stop-class fault of a port is latched.
		if (stop_mask_cfg[c] && stop_latch[p] == '0)
			stop_latch[p] = c;
		return log_report(p, c, 1'b1) ? STAT_DONE : STAT_DROP;
	endfunction

	function automatic logic [STAT_W-1:0] drop_fault(input int p,
			input logic [CODE_W-1:0] c);
		if (!code_valid(c) || !fault_on[p][c])
			return STAT_NOP;
		fault_on[p][c] = 1'b0;
		if (stop_latch[p] == c)
			stop_latch[p] = '0;
		return log_report(p, c, 1'b0) ? STAT_DONE : STAT_DROP;
	endfunction

	// Applies one accepted request to the mirror and returns its result.
	function automatic fault_res_t predict_result(input fault_req_t r);
		fault_res_t res;
		int p;
		int s;
		logic [CODE_W-1:0] c;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] need_ms;
		logic [REPORT_W-1:0] entry;
		res = '0;
		res.status = STAT_NOP;
		p = r.port;
		s = r.slot;
		c = r.code;
		case (r.kind)
		KIND_CHECK: begin
			// The condition has to differ from the flag for the whole delay;
			// the stamp restarts whenever they agree or the delay runs out.
			c = slot_code_tab[s];
			elapsed = r.now_ms - debounce_ms[p][s];
			if (fault_on[p][c]) begin
				if (!r.raw_on) begin
					need_ms = slot_clear_tab[s];
					if (need_ms < min_clear_cfg)
						need_ms = min_clear_cfg;
					if (elapsed >= need_ms) begin
						res.status = drop_fault(p, c);
						debounce_ms[p][s] = r.now_ms;
					end
				end else begin
					debounce_ms[p][s] = r.now_ms;
				end
			end else begin
				if (r.raw_on) begin
					if (elapsed >= slot_appear_tab[s]) begin
						res.status = raise_fault(p, c);
						debounce_ms[p][s] = r.now_ms;
					end
				end else begin
					debounce_ms[p][s] = r.now_ms;
				end
			end
			res.changed = res.status != STAT_NOP;
		end
		KIND_SET: begin
			res.status = raise_fault(p, c);
			res.changed = res.status != STAT_NOP;
		end
		KIND_CLEAR: begin
			res.status = drop_fault(p, c);
			res.changed = res.status != STAT_NOP;
		end
		KIND_POP: begin
			if (report_count[p] != 0) begin
				entry = report_mem[p][report_head[p]];
				report_head[p] = (report_head[p] + 1) % QUEUE_DEPTH;
				report_count[p]--;
				res.status = STAT_DONE;
				res.rep_valid = 1'b1;
				res.rep_code = entry[CODE_W-1:0];
				res.rep_set = entry[CODE_W];
			end
		end
		KIND_LOAD: begin
			slot_code_tab[s] = r.code;
			slot_appear_tab[s] = r.appear_ms;
			slot_clear_tab[s] = r.disappear_ms;
			res.status = STAT_DONE;
		end
		default: ;
		endcase
		res.present = fault_on[p][c];
		res.first_stop = stop_latch[p];
		return res;
	endfunction

	function automatic void add_req(input logic [KIND_W-1:0] kind, input int port,
			input int slot, input logic [CODE_W-1:0] code, input logic raw,
			input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] appear,
			input logic [TIME_W-1:0] disappear);
		fault_req_t r;
		r.kind = kind;
		r.port = port;
		r.slot = slot;
		r.code = code;
		r.raw_on = raw;
		r.now_ms = now;
		r.appear_ms = appear;
		r.disappear_ms = disappear;
		if (kind == KIND_LOAD)
			slot_ready[r.slot] = 1'b1;
		pending_reqs.push_back(r);
	endfunction

	// Codes lean on a small pool so that faults get set and cleared again,
	// with the whole valid range and invalid codes mixed in.
	function automatic logic [CODE_W-1:0] pick_code();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return $urandom_range(1, 8);
		if (pick < 85)
			return $urandom_range(1, limit_cfg - 1);
		return $urandom_range(0, NUM_CODES - 1);
	endfunction

	// Random requests. Half of them are checks on loaded slots with a raw
	// condition that persists for a while and a clock that moves forward by
	// amounts around the debounce delays or jumps; the rest are pops, direct
	// sets and clears, slot loads and unknown kinds.
	function automatic void gen_random(input int count);
		int pick;
		int p;
		int s;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			p = $urandom_range(0, PORTS - 1);
			if (pick < 50) begin
				s = $urandom_range(0, SLOTS - 1);
				while (!slot_ready[s])
					s = $urandom_range(0, SLOTS - 1);
				if ($urandom_range(0, 99) < 30)
					raw_wish[p][s] = !raw_wish[p][s];
				pick = $urandom_range(0, 99);
				if (pick < 15)
					ms_cursor += $urandom_range(0, 3);
				else if (pick < 55)
					ms_cursor += $urandom_range(1, 150);
				else if (pick < 85)
					ms_cursor += $urandom_range(100, 700);
				else if (pick < 95)
					ms_cursor += $urandom_range(1000, 70000);
				else
					ms_cursor = $urandom;
				add_req(KIND_CHECK, p, s, $urandom_range(0, NUM_CODES - 1), raw_wish[p][s],
					ms_cursor, $urandom, $urandom);
			end else if (pick < 50 + pop_pct) begin
				add_req(KIND_POP, p, $urandom_range(0, SLOTS - 1), pick_code(),
					$urandom_range(0, 1), ms_cursor, $urandom, $urandom);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					add_req(KIND_SET, p, $urandom_range(0, SLOTS - 1), pick_code(),
						$urandom_range(0, 1), $urandom, $urandom, $urandom);
				else if (pick < 78)
					add_req(KIND_CLEAR, p, $urandom_range(0, SLOTS - 1), pick_code(),
						$urandom_range(0, 1), $urandom, $urandom, $urandom);
				else if (pick < 95)
					add_req(KIND_LOAD, p, $urandom_range(0, SLOTS - 1), pick_code(),
						$urandom_range(0, 1), $urandom,
						($urandom_range(0, 99) < 80) ? $urandom_range(0, 300) : $urandom,
						($urandom_range(0, 99) < 80) ? $urandom_range(0, 500) : $urandom);
				else
					add_req($urandom_range(KIND_LOAD + 1, (1 << KIND_W) - 1), p,
						$urandom_range(0, SLOTS - 1), pick_code(), $urandom_range(0, 1),
						$urandom, $urandom, $urandom);
			end
		end
	endfunction

	// Register writes happen only while the block is idle, so the mirror
	// can follow them at once.
	task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_CODE_LIMIT: limit_cfg = value[LIMIT_W-1:0];
		CFG_STOP_MASK:  stop_mask_cfg = value;
		CFG_MIN_CLEAR:  min_clear_cfg = value[MINC_W-1:0];
		default: ;
		endcase
	endtask

	// Phase settings change away from the rising edge, where the clocked
	// processes read them.
	task automatic begin_phase(input int send_pct, input int recv_pct, input int pops);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		pop_pct = pops;
	endtask

	// Every request yields one result, so the block is idle once nothing is
	// queued, offered or expected; an extra wait then covers its pipeline.
	task automatic drain();
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: predicts each request at the edge where it is accepted, then
	// offers the next one unless this cycle is an idle one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_result(offered_req));
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					offered_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered_req.disappear_ms, offered_req.appear_ms,
						offered_req.now_ms, offered_req.raw_on, offered_req.code,
						offered_req.slot, offered_req.port};
					s_tuser <= offered_req.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: once armed, the receiver stays stalled for a long
	// stretch while the driver keeps offering, so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done && s_tvalid) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		fault_res_t got;
		fault_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_count++;
				got.status = m_tdata[1:0];
				got.present = m_tdata[2];
				got.changed = m_tdata[3];
				got.first_stop = m_tdata[9:4];
				got.rep_valid = m_tdata[10];
				got.rep_code = m_tdata[16:11];
				got.rep_set = m_tdata[17];
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d arrived with no request outstanding: %h",
							result_count, m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.present !== want.present ||
							got.changed !== want.changed ||
							got.first_stop !== want.first_stop ||
							got.rep_valid !== want.rep_valid ||
							got.rep_code !== want.rep_code || got.rep_set !== want.rep_set) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result %0d: expected st %0d fp %0b ch %0b stop %0d",
								" rep %0b/%0d/%0b, got st %0d fp %0b ch %0b stop %0d",
								" rep %0b/%0d/%0b"}, result_count,
								want.status, want.present, want.changed, want.first_stop,
								want.rep_valid, want.rep_code, want.rep_set,
								got.status, got.present, got.changed, got.first_stop,
								got.rep_valid, got.rep_code, got.rep_set);
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: stops a run that hangs and reports it as mismatches.
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		// The mirror starts in the block's reset state.
		limit_cfg = CODE_LIMIT_RST;
		stop_mask_cfg = '0;
		min_clear_cfg = MIN_CLEAR_RST;
		foreach (fault_on[p, c])
			fault_on[p][c] = 1'b0;
		foreach (debounce_ms[p, s]) begin
			debounce_ms[p][s] = '0;
			raw_wish[p][s] = 1'b0;
		end
		foreach (stop_latch[p]) begin
			stop_latch[p] = '0;
			report_head[p] = 0;
			report_count[p] = 0;
		end
		foreach (slot_ready[s])
			slot_ready[s] = 1'b0;
		ms_cursor = 32'd1000;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings, with two codes made
		// stop-class so that latching and its release can be seen.
		write_reg(CFG_STOP_MASK, (64'd1 << 45) | (64'd1 << 2));
		begin_phase(0, 0, 20);
		add_req(KIND_LOAD, 0, 0, 1, 1'b0, 0, 0, 0);
		add_req(KIND_LOAD, 0, SLOTS - 1, NUM_CODES - 1, 1'b0, 0, '1, '1);
		add_req(KIND_LOAD, 1, 5, 2, 1'b0, 0, 100, 300);
		// Zero appear delay sets at once; the clear waits for the minimum
		// clear delay even though the slot's own is zero.
		add_req(KIND_CHECK, 0, 0, 0, 1'b1, 0, 0, 0);
		add_req(KIND_CHECK, 0, 0, 0, 1'b0, 100, 0, 0);
		add_req(KIND_CHECK, 0, 0, 0, 1'b0, 300, 0, 0);
		// Maximum delay passes at maximum elapsed time, but the slot's code
		// is beyond the code limit, so nothing changes.
		add_req(KIND_CHECK, 1, SLOTS - 1, 0, 1'b1, '1, 0, 0);
		// Condition agrees first, then must hold for the full appear delay.
		add_req(KIND_CHECK, 1, 5, 0, 1'b0, 50, 0, 0);
		add_req(KIND_CHECK, 1, 5, 0, 1'b1, 120, 0, 0);
		add_req(KIND_CHECK, 1, 5, 0, 1'b1, 150, 0, 0);
		// Direct sets and clears: code zero, code at the limit, a stop-class
		// code twice, a second stop-class code, an absent clear, a release.
		add_req(KIND_SET, 0, 0, 0, 1'b0, 0, 0, 0);
		add_req(KIND_SET, 0, 0, 46, 1'b0, 0, 0, 0);
		add_req(KIND_SET, 0, 0, 45, 1'b0, 0, 0, 0);
		add_req(KIND_SET, 0, 0, 45, 1'b0, 0, 0, 0);
		add_req(KIND_SET, 0, 0, 2, 1'b0, 0, 0, 0);
		add_req(KIND_CLEAR, 0, 0, 44, 1'b0, 0, 0, 0);
		add_req(KIND_CLEAR, 0, 0, 45, 1'b0, 0, 0, 0);
		// Pops until one port's queue runs empty, then unknown kinds.
		add_req(KIND_POP, 1, 0, 0, 1'b0, 0, 0, 0);
		add_req(KIND_POP, 1, 0, 0, 1'b0, 0, 0, 0);
		add_req(KIND_POP, 0, 0, 0, 1'b0, 0, 0, 0);
		add_req(KIND_LOAD + 1, 0, 0, 1, 1'b1, 0, 0, 0);
		add_req((1 << KIND_W) - 1, 1, SLOTS - 1, NUM_CODES - 1, 1'b1, '1, '1, '1);
		drain();

		// Widest code range, every code stop-class, no minimum clear delay.
		// Few pops, so the report queues fill and reports get dropped.
		write_reg(CFG_CODE_LIMIT, 64);
		write_reg(CFG_STOP_MASK, '1);
		write_reg(CFG_MIN_CLEAR, 0);
		begin_phase(0, 0, 4);
		gen_random(200);
		drain();

		// No valid code at all and the longest minimum clear delay; the
		// sender idles most of the time.
		write_reg(CFG_CODE_LIMIT, 1);
		write_reg(CFG_STOP_MASK, '0);
		write_reg(CFG_MIN_CLEAR, 16'hFFFF);
		begin_phase(66, 0, 25);
		gen_random(70);
		drain();

		// Random middle settings; the receiver stalls most of the time.
		write_reg(CFG_CODE_LIMIT, $urandom_range(8, 60));
		write_reg(CFG_STOP_MASK, {$urandom, $urandom});
		write_reg(CFG_MIN_CLEAR, $urandom_range(0, 400));
		begin_phase(0, 66, 20);
		gen_random(200);
		drain();

		// Reset settings again, both sides idling, the clock wrapping
		// through zero, and one long receiver hold-off near the start.
		write_reg(CFG_CODE_LIMIT, CODE_LIMIT_RST);
		write_reg(CFG_STOP_MASK, {$urandom, $urandom});
		write_reg(CFG_MIN_CLEAR, MIN_CLEAR_RST);
		begin_phase(28, 28, 15);
		hold_armed = 1'b1;
		ms_cursor = 32'hFFFF_F000;
		gen_random(230);
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
